// ----- sv/rpc_pkg.sv -----
// rpc_pkg: shared types, constants and elaboration-time helpers for the
// rectangular/polar converter. No dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

	// Guard bits carried below the Q8.8 point through the rotations
	localparam int GUARD_BITS = 16;
	// Fraction bits of the inverse gain constant
	localparam int GAIN_FRAC = 30;
	// Deepest supported rotation chain
	localparam int MAX_STAGES = 24;
	// Width of the angle accumulator: 32 bits per turn plus headroom
	localparam int ANG_W = 34;

	// Arctangent of 2^-i in units of 2^-32 turn
	localparam logic [31:0] TURN_ATAN [0:MAX_STAGES-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Control bits that travel with each transaction
	typedef struct packed {
		logic mode;   // 0 vectoring, 1 rotation
		logic zero;   // vectoring of the zero vector
		logic flip;   // operand turned by half a turn
	} rpc_ctrl_t;

	// Integer square root, bit-pair method
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem = v;
		root = 64'd0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (rem >= root + b) begin
					rem = rem - (root + b);
					root = (root >> 1) + b;
				end else begin
					root = root >> 1;
				end
				b = b >> 2;
			end
		end
		return root;
	endfunction

	// Inverse CORDIC gain in Q30, restoring long division for the reciprocal
	function automatic logic [63:0] inv_gain(input int stages);
		logic [63:0] g;
		logic [63:0] s;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		g = 64'd1 << GAIN_FRAC;
		for (int i = 0; i < MAX_STAGES; i++) begin
			if (i < stages) begin
				s = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
				g = (g * s + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
			end
		end
		num = (64'd1 << 60) + (g >> 1);
		rem = 64'd0;
		q = 64'd0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], num[k]};
			if (rem >= g) begin
				rem = rem - g;
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

endpackage

// ----- sv/rpc_cordic_stage.sv -----
// rpc_cordic_stage: one registered CORDIC micro-rotation, vectoring or
// rotation per transaction. Depends on rpc_pkg.
`timescale 1ns / 1ps

module rpc_cordic_stage #(
	parameter int IW = 34,
	parameter int SHIFT = 0,
	parameter logic [31:0] ATAN = 32'h20000000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_in,
	input  rpc_pkg::rpc_ctrl_t             ctrl_in,
	input  logic signed [IW-1:0]           x_in,
	input  logic signed [IW-1:0]           y_in,
	input  logic signed [rpc_pkg::ANG_W-1:0] z_in,
	output logic                           valid_out,
	output rpc_pkg::rpc_ctrl_t             ctrl_out,
	output logic signed [IW-1:0]           x_out,
	output logic signed [IW-1:0]           y_out,
	output logic signed [rpc_pkg::ANG_W-1:0] z_out
);

	localparam logic signed [rpc_pkg::ANG_W-1:0] ATAN_Z =
		$signed(rpc_pkg::ANG_W'(ATAN));

	logic signed [IW-1:0] dx;
	logic signed [IW-1:0] dy;
	logic ccw;
	logic signed [IW-1:0] x_nx;
	logic signed [IW-1:0] y_nx;
	logic signed [rpc_pkg::ANG_W-1:0] z_nx;

	logic rot_v_s1;
	rpc_pkg::rpc_ctrl_t rot_c_s1;
	logic signed [IW-1:0] rot_x_s1;
	logic signed [IW-1:0] rot_y_s1;
	logic signed [rpc_pkg::ANG_W-1:0] rot_z_s1;

	always_comb begin
		dx = y_in >>> SHIFT;
		dy = x_in >>> SHIFT;
		// vectoring drives y to zero, rotation drives z to zero
		ccw = ctrl_in.mode ? !z_in[rpc_pkg::ANG_W-1] : y_in[IW-1];
		if (ccw) begin
			x_nx = x_in - dx;
			y_nx = y_in + dy;
			z_nx = z_in - ATAN_Z;
		end else begin
			x_nx = x_in + dx;
			y_nx = y_in - dy;
			z_nx = z_in + ATAN_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s1 <= 1'b0;
		end else if (en) begin
			rot_v_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_c_s1 <= ctrl_in;
			rot_x_s1 <= x_nx;
			rot_y_s1 <= y_nx;
			rot_z_s1 <= z_nx;
		end
	end

	assign valid_out = rot_v_s1;
	assign ctrl_out = rot_c_s1;
	assign x_out = rot_x_s1;
	assign y_out = rot_y_s1;
	assign z_out = rot_z_s1;

endmodule

// ----- sv/rect_polar_converter_top.sv -----
// rect_polar_converter_top: pipelined CORDIC converter between rectangular
// and polar form. Depends on rpc_pkg and rpc_cordic_stage.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready carries mode, first_value, second_value.
//   mode 0: (x, y) in Q8.8 -> magnitude in first_result, atan2(y, x) in
//   second_result as a binary angle (2^VALUE_WIDTH counts per turn).
//   mode 1: (magnitude, angle) -> x in first_result, y in second_result.
//   Output channel out_valid/out_ready carries first_result, second_result.
// Timing
//   A transaction passes through one multiply stage for the gain correction,
//   one rounding and half-turn stage, one stage per micro-rotation, and one
//   rounding and saturation stage before its result is valid. One transaction
//   per cycle is accepted sustained while the output is not stalled.
// Reset
//   arst_n clears every valid bit at once; the pipeline is empty afterwards.
// Backpressure
//   Each stage holds while its successor is full and holding; in_ready falls
//   only when every stage holds a transaction and out_ready is low. Bubbles
//   compress on a stall and nothing is dropped or repeated.

module rect_polar_converter_top #(
	parameter int CORDIC_STAGES = 16,
	parameter int VALUE_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic signed [VALUE_WIDTH-1:0] first_value,
	input  logic signed [VALUE_WIDTH-1:0] second_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_WIDTH:0]   first_result,
	output logic signed [VALUE_WIDTH-1:0] second_result
);

	localparam int W = VALUE_WIDTH;
	localparam int N = CORDIC_STAGES;
	localparam int ZW = rpc_pkg::ANG_W;
	localparam int PW = W + 32;
	localparam int IW = W + 18;
	localparam int UW = IW - rpc_pkg::GUARD_BITS;
	localparam int PRE_SH = rpc_pkg::GAIN_FRAC - rpc_pkg::GUARD_BITS;

	localparam logic signed [31:0] INV_S = $signed(32'(rpc_pkg::inv_gain(N)));
	localparam logic signed [PW-1:0] PRE_RND = PW'(64'd1 << (PRE_SH - 1));
	localparam logic signed [IW-1:0] POST_RND = IW'(64'd1 << (rpc_pkg::GUARD_BITS - 1));
	localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1 << 30);
	localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << 31);
	localparam logic signed [UW-1:0] RES_LO = UW'(-(64'sd1 <<< (W - 1)));
	localparam logic signed [UW-1:0] RES_HI = UW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [UW-1:0] MAG_HI =
		UW'(rpc_pkg::isqrt64(64'd1 << (2 * W - 1)) + 64'd1);

	// ---------------- stage 1: gain correction multiply ----------------
	logic en_s1;
	logic en_s2;
	logic en_out;
	logic [31:0] turn_in;
	logic signed [ZW-1:0] z_raw;
	logic flip_rot;
	rpc_pkg::rpc_ctrl_t ctrl_in;
	logic signed [ZW-1:0] z_init;

	logic v_s1;
	rpc_pkg::rpc_ctrl_t c_s1;
	logic signed [PW-1:0] px_s1;
	logic signed [PW-1:0] py_s1;
	logic signed [ZW-1:0] z_s1;

	always_comb begin
		turn_in = 32'(64'(second_value) << (32 - W));
		z_raw = ZW'($signed(turn_in));
		flip_rot = (z_raw > QUARTER) || (z_raw < -QUARTER);
		ctrl_in.mode = mode;
		ctrl_in.zero = !mode && (first_value == '0) && (second_value == '0);
		ctrl_in.flip = mode ? flip_rot : first_value[W-1];
		if (mode) begin
			if (flip_rot) begin
				z_init = (z_raw > 0) ? z_raw - HALF : z_raw + HALF;
			end else begin
				z_init = z_raw;
			end
		end else begin
			z_init = first_value[W-1] ? HALF : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1 <= ctrl_in;
			px_s1 <= PW'(first_value) * PW'(INV_S);
			py_s1 <= PW'(second_value) * PW'(INV_S);
			z_s1 <= z_init;
		end
	end

	// ---------------- stage 2: round to guard bits, half-turn ----------------
	logic signed [PW-1:0] sx;
	logic signed [PW-1:0] sy;
	logic signed [IW-1:0] rx;
	logic signed [IW-1:0] ry;

	logic v_s2;
	rpc_pkg::rpc_ctrl_t c_s2;
	logic signed [IW-1:0] x_s2;
	logic signed [IW-1:0] y_s2;
	logic signed [ZW-1:0] z_s2;

	always_comb begin
		sx = (px_s1 + PRE_RND) >>> PRE_SH;
		sy = (py_s1 + PRE_RND) >>> PRE_SH;
		rx = $signed(sx[IW-1:0]);
		ry = $signed(sy[IW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			c_s2 <= c_s1;
			x_s2 <= c_s1.flip ? -rx : rx;
			// rotation starts on the x axis
			y_s2 <= c_s1.mode ? '0 : (c_s1.flip ? -ry : ry);
			z_s2 <= z_s1;
		end
	end

	// ---------------- micro-rotations ----------------
	logic rv [0:N];
	rpc_pkg::rpc_ctrl_t rc [0:N];
	logic signed [IW-1:0] rx_p [0:N];
	logic signed [IW-1:0] ry_p [0:N];
	logic signed [ZW-1:0] rz_p [0:N];
	logic re [0:N-1];

	assign rv[0] = v_s2;
	assign rc[0] = c_s2;
	assign rx_p[0] = x_s2;
	assign ry_p[0] = y_s2;
	assign rz_p[0] = z_s2;

	for (genvar k = 0; k < N; k++) begin : g_rot
		if (k == N - 1) begin : g_last
			assign re[k] = !rv[k+1] || en_out;
		end else begin : g_mid
			assign re[k] = !rv[k+1] || re[k+1];
		end

		rpc_cordic_stage #(
			.IW(IW),
			.SHIFT(k),
			.ATAN(rpc_pkg::TURN_ATAN[k])
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(re[k]),
			.valid_in(rv[k]),
			.ctrl_in(rc[k]),
			.x_in(rx_p[k]),
			.y_in(ry_p[k]),
			.z_in(rz_p[k]),
			.valid_out(rv[k+1]),
			.ctrl_out(rc[k+1]),
			.x_out(rx_p[k+1]),
			.y_out(ry_p[k+1]),
			.z_out(rz_p[k+1])
		);
	end

	assign en_out = !out_valid || out_ready;
	assign en_s2 = !v_s2 || re[0];
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// ---------------- output: unscale, saturate ----------------
	logic signed [IW-1:0] ux_full;
	logic signed [IW-1:0] uy_full;
	logic signed [UW-1:0] ux;
	logic signed [UW-1:0] uy;
	logic signed [UW-1:0] cx;
	logic signed [UW-1:0] cy;
	logic [31:0] acc;
	logic [W-1:0] angle;

	logic out_v_q;
	logic out_zero_q;
	logic signed [W:0] first_q;
	logic signed [W-1:0] second_q;

	always_comb begin
		ux_full = (rx_p[N] + POST_RND) >>> rpc_pkg::GUARD_BITS;
		uy_full = (ry_p[N] + POST_RND) >>> rpc_pkg::GUARD_BITS;
		ux = $signed(ux_full[UW-1:0]);
		uy = $signed(uy_full[UW-1:0]);
		if (ux < RES_LO) begin
			cx = RES_LO;
		end else if (ux > MAG_HI) begin
			cx = MAG_HI;
		end else begin
			cx = ux;
		end
		if (uy < RES_LO) begin
			cy = RES_LO;
		end else if (uy > RES_HI) begin
			cy = RES_HI;
		end else begin
			cy = uy;
		end
		acc = rz_p[N][31:0];
	end

	if (W < 32) begin : g_ang_round
		logic [32:0] acc_rnd;
		always_comb begin
			acc_rnd = 33'(acc) + (33'd1 << (31 - W));
			angle = W'(acc_rnd >> (32 - W));
		end
	end else begin : g_ang_full
		assign angle = W'(acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= rv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_zero_q <= rc[N].zero;
			if (rc[N].zero) begin
				first_q <= '0;
				second_q <= '0;
			end else begin
				first_q <= $signed(cx[W:0]);
				second_q <= rc[N].mode ? $signed(cy[W-1:0]) : $signed(angle);
			end
		end
	end

	assign out_valid = out_v_q;
	assign first_result = first_q;
	assign second_result = second_q;

	// ---------------- checks ----------------
	logic all_full;
	always_comb begin
		all_full = v_s1 && v_s2 && out_v_q;
		for (int k = 1; k <= N; k++) begin
			all_full = all_full && rv[k];
		end
	end

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while the output side is taking results");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> all_full)
		else $error("input stalled with a bubble in the pipeline");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zero_q |-> first_result == '0 && second_result == '0)
		else $error("zero vector gave a nonzero result");

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for rect_polar_converter_top in both conversion modes,
// with an internal bit-exact CORDIC predictor, random idling and a long output hold-off.
// Depends only on rect_polar_converter_top and the files it pulls in.
`timescale 1ns / 1ps

module tb_top;

	localparam int STAGES = 16;
	localparam int VW = 16;
	localparam int GUARD = 16;
	localparam int GAIN_Q = 30;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = STAGES + 24;
	localparam int HOLD_OFF_CYCLES = 300;

	localparam logic MODE_VECTORING = 1'b0;
	localparam logic MODE_ROTATION = 1'b1;

	localparam longint QUARTER_TURN = 64'sd1 <<< 30;
	localparam longint HALF_TURN = 64'sd1 <<< 31;
	localparam longint COORD_LO = -(64'sd1 <<< (VW - 1));
	localparam longint COORD_HI = (64'sd1 <<< (VW - 1)) - 1;

	// atan(2^-i) in units of 2^-32 turn
	localparam longint ATAN_STEP [0:STAGES-1] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
	};

	typedef struct packed {
		logic [VW:0]   mag_or_x;
		logic [VW-1:0] angle_or_y;
	} conv_out_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 mode = 1'b0;
	logic signed [VW-1:0] first_value = '0;
	logic signed [VW-1:0] second_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [VW:0]   first_result;
	logic signed [VW-1:0] second_result;

	conv_out_t pending_results[$];
	longint    gain_inv;
	longint    mag_ceiling;
	int        fail_count = 0;
	int        src_idle_pct = 0;
	int        sink_stall_pct = 0;
	int        hold_request = 0;
	int        hold_left = 0;
	int        idle_cycles = 0;

	rect_polar_converter_top #(
		.CORDIC_STAGES(STAGES),
		.VALUE_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.first_value(first_value),
		.second_value(second_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.first_result(first_result),
		.second_result(second_result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			trial = r | (64'd1 << k);
			if (trial * trial <= v) begin
				r = trial;
			end
		end
		return r;
	endfunction

	// Reciprocal of the rounded CORDIC gain, Q30
	function automatic longint inverse_gain_q30();
		longint unsigned g;
		longint unsigned s;
		g = 64'd1 << GAIN_Q;
		for (int i = 0; i < STAGES; i++) begin
			s = floor_root((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
			g = (g * s + (64'd1 << (GAIN_Q - 1))) >> GAIN_Q;
		end
		return longint'(((64'd1 << 60) + g / 2) / g);
	endfunction

	function automatic longint gain_correct(input longint v);
		return (v * gain_inv + (64'sd1 <<< (GAIN_Q - GUARD - 1))) >>> (GAIN_Q - GUARD);
	endfunction

	function automatic longint drop_guard(input longint v);
		return (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic conv_out_t predict_conversion(input logic m,
			input logic signed [VW-1:0] a_in, input logic signed [VW-1:0] b_in);
		conv_out_t       r;
		longint          a;
		longint          b;
		longint          x;
		longint          y;
		longint          z;
		longint          dx;
		longint          dy;
		longint unsigned turn_acc;
		a = a_in;
		b = b_in;
		turn_acc = 0;
		z = 0;
		if (m == MODE_VECTORING) begin
			if (a == 0 && b == 0) begin
				r = '0;
			end else begin
				x = gain_correct(a);
				y = gain_correct(b);
				// fold the left half plane onto the right one
				if (x < 0) begin
					x = -x;
					y = -y;
					turn_acc = longint'(HALF_TURN);
				end
				for (int i = 0; i < STAGES; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (y >= 0) begin
						x = x + dx;
						y = y - dy;
						turn_acc = turn_acc + ATAN_STEP[i];
					end else begin
						x = x - dx;
						y = y + dy;
						turn_acc = turn_acc - ATAN_STEP[i];
					end
				end
				turn_acc = turn_acc & 64'hFFFF_FFFF;
				turn_acc = (turn_acc + (64'd1 << (31 - VW))) >> (32 - VW);
				x = clamp_to(drop_guard(x), COORD_LO, mag_ceiling);
				r.mag_or_x = x[VW:0];
				r.angle_or_y = turn_acc[VW-1:0];
			end
		end else begin
			z = b <<< (32 - VW);
			x = gain_correct(a);
			// bring angles beyond a quarter turn back by half a turn
			if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
				z = (z > 0) ? z - HALF_TURN : z + HALF_TURN;
				x = -x;
			end
			y = 0;
			for (int i = 0; i < STAGES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_STEP[i];
				end
			end
			x = clamp_to(drop_guard(x), COORD_LO, mag_ceiling);
			y = clamp_to(drop_guard(y), COORD_LO, COORD_HI);
			r.mag_or_x = x[VW:0];
			r.angle_or_y = y[VW-1:0];
		end
		return r;
	endfunction

	// Record the expected result of every input transaction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			pending_results.push_back(predict_conversion(mode, first_value, second_value));
		end
	end

	always @(posedge clk) begin
		conv_out_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: first_result=%0d second_result=%0d",
					first_result, second_result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (first_result !== want.mag_or_x) begin
					$error("first_result expected %0d, got %0d",
						$signed(want.mag_or_x), first_result);
					fail_count++;
				end
				if (second_result !== want.angle_or_y) begin
					$error("second_result expected %0d, got %0d",
						$signed(want.angle_or_y), second_result);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one transaction, idling first at the current source rate
	task automatic send_vector(input logic m, input logic [VW-1:0] a, input logic [VW-1:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		first_value <= a;
		second_value <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [VW-1:0] pick_operand();
		logic [VW-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(7))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					3: v = 16'hFFFF;
					4: v = 16'h4000;
					5: v = 16'hC000;
					6: v = 16'h4001;
					default: v = 16'hBFFF;
				endcase
			end
			1, 2: v = VW'($urandom_range(1023) - 512);
			default: v = VW'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_random_items(input int count);
		for (int n = 0; n < count; n++) begin
			send_vector($urandom_range(1) ? MODE_ROTATION : MODE_VECTORING,
				pick_operand(), pick_operand());
		end
	endtask

	task automatic test_vectoring_corners();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_vector(MODE_VECTORING, 16'h0000, 16'h0000);
		send_vector(MODE_VECTORING, 16'h0100, 16'h0000);
		send_vector(MODE_VECTORING, 16'h0000, 16'h0100);
		send_vector(MODE_VECTORING, 16'h0000, 16'hFF00);
		send_vector(MODE_VECTORING, 16'hFF00, 16'h0000);
		send_vector(MODE_VECTORING, 16'h8000, 16'h0000);
		send_vector(MODE_VECTORING, 16'h7FFF, 16'h7FFF);
		send_vector(MODE_VECTORING, 16'h8000, 16'h8000);
		send_vector(MODE_VECTORING, 16'h8000, 16'h7FFF);
		send_vector(MODE_VECTORING, 16'h7FFF, 16'h8000);
		send_vector(MODE_VECTORING, 16'hFFFF, 16'h0001);
		send_vector(MODE_VECTORING, 16'h0001, 16'h0000);
	endtask

	task automatic test_rotation_corners();
		send_vector(MODE_ROTATION, 16'h7FFF, 16'h0000);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'h4000);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'h4001);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'hC000);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'hBFFF);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'h8000);
		send_vector(MODE_ROTATION, 16'h8000, 16'h2000);
		send_vector(MODE_ROTATION, 16'h8000, 16'h7FFF);
		send_vector(MODE_ROTATION, 16'h0000, 16'h1234);
		send_vector(MODE_ROTATION, 16'h0100, 16'hFFFF);
		send_vector(MODE_ROTATION, 16'h7FFF, 16'h6000);
	endtask

	task automatic test_streaming();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		send_random_items(300);
	endtask

	task automatic test_source_gaps();
		src_idle_pct = 47;
		sink_stall_pct = 0;
		send_random_items(300);
	endtask

	task automatic test_sink_stalls();
		src_idle_pct = 0;
		sink_stall_pct = 47;
		send_random_items(300);
	endtask

	task automatic test_mixed_idling();
		src_idle_pct = 26;
		sink_stall_pct = 26;
		send_random_items(300);
	endtask

	// Hold the output off long enough that the pipeline fills and input stalls
	task automatic test_backpressure_fill();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_request = HOLD_OFF_CYCLES;
		send_random_items(120);
	endtask

	initial begin
		gain_inv = inverse_gain_q30();
		mag_ceiling = longint'(floor_root(64'd1 << (2 * VW - 1))) + 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_vectoring_corners();
		test_rotation_corners();
		test_streaming();
		test_source_gaps();
		test_sink_stalls();
		test_mixed_idling();
		test_backpressure_fill();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/rpc_pkg.sv
sv/rpc_cordic_stage.sv
sv/rect_polar_converter_top.sv
tb/sv/tb_top.sv
